### hw/rtl/edts_pkg.sv
// Shared types and constants for the earliest date token scanner.
`timescale 1ns / 1ps

package edts_pkg;

	localparam int unsigned CH_W   = 8;
	localparam int unsigned DAY_W  = 7;
	localparam int unsigned MON_W  = 7;
	localparam int unsigned YEAR_W = 14;
	localparam int unsigned POS_W  = 4;

	localparam logic [POS_W-1:0] DATE_LEN   = 4'd10;
	localparam logic [POS_W-1:0] POS_SAT    = 4'd11;
	localparam logic [POS_W-1:0] POS_DOT1   = 4'd2;
	localparam logic [POS_W-1:0] POS_DOT2   = 4'd5;

	localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

	// One input transaction as seen by the scanner core.
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            eot;
	} step_t;

	// Result of a stream, valid on the end-of-text transaction.
	typedef struct packed {
		logic              found;
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
	} result_t;

endpackage

### hw/rtl/edts_core.sv
// Token state, date accumulators and earliest-date comparison.
`timescale 1ns / 1ps

module edts_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  edts_pkg::step_t  step,
	output edts_pkg::result_t res
);
	import edts_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic              tok_ok_q;
	logic [DAY_W-1:0]  acc_day_q;
	logic [MON_W-1:0]  acc_month_q;
	logic [YEAR_W-1:0] acc_year_q;
	logic [DAY_W-1:0]  best_day_q;
	logic [MON_W-1:0]  best_month_q;
	logic [YEAR_W-1:0] best_year_q;
	logic              have_best_q;

	logic [POS_W-1:0]  pos_d;
	logic              tok_ok_d;
	logic [DAY_W-1:0]  acc_day_d;
	logic [MON_W-1:0]  acc_month_d;
	logic [YEAR_W-1:0] acc_year_d;
	logic [DAY_W-1:0]  best_day_d;
	logic [MON_W-1:0]  best_month_d;
	logic [YEAR_W-1:0] best_year_d;
	logic              have_best_d;

	logic              is_sep;
	logic              is_digit;
	logic [3:0]        digit;
	logic              close_tok;
	logic              is_date;
	logic              earlier;
	logic [DAY_W-1:0]  day_n;
	logic [MON_W-1:0]  month_n;
	logic [YEAR_W-1:0] year_n;
	logic              have_n;

	always_comb begin
		is_sep   = (step.ch inside {CH_SPACE, [CH_TAB:CH_CR]});
		is_digit = (step.ch inside {[CH_ZERO:CH_NINE]});
		digit    = is_digit ? step.ch[3:0] : 4'd0;
		close_tok = step.eot || is_sep;

		// Lexicographic order on {year, month, day} is a plain compare of the concatenation.
		is_date = tok_ok_q && (pos_q == DATE_LEN);
		earlier = !have_best_q ||
			({acc_year_q, acc_month_q, acc_day_q} < {best_year_q, best_month_q, best_day_q});
		if (is_date && earlier) begin
			day_n   = acc_day_q;
			month_n = acc_month_q;
			year_n  = acc_year_q;
			have_n  = 1'b1;
		end else begin
			day_n   = best_day_q;
			month_n = best_month_q;
			year_n  = best_year_q;
			have_n  = have_best_q;
		end

		res.found = have_n;
		res.day   = day_n;
		res.month = month_n;
		res.year  = year_n;

		pos_d        = pos_q;
		tok_ok_d     = tok_ok_q;
		acc_day_d    = acc_day_q;
		acc_month_d  = acc_month_q;
		acc_year_d   = acc_year_q;
		best_day_d   = best_day_q;
		best_month_d = best_month_q;
		best_year_d  = best_year_q;
		have_best_d  = have_best_q;

		if (step.eot) begin
			// The stream ends: everything returns to its reset value.
			pos_d        = '0;
			tok_ok_d     = 1'b1;
			acc_day_d    = '0;
			acc_month_d  = '0;
			acc_year_d   = '0;
			best_day_d   = '0;
			best_month_d = '0;
			best_year_d  = '0;
			have_best_d  = 1'b0;
		end else if (close_tok) begin
			pos_d        = '0;
			tok_ok_d     = 1'b1;
			acc_day_d    = '0;
			acc_month_d  = '0;
			acc_year_d   = '0;
			best_day_d   = day_n;
			best_month_d = month_n;
			best_year_d  = year_n;
			have_best_d  = have_n;
		end else begin
			if (pos_q >= DATE_LEN) begin
				tok_ok_d = 1'b0;
			end else if (pos_q == POS_DOT1 || pos_q == POS_DOT2) begin
				if (step.ch != CH_DOT) begin
					tok_ok_d = 1'b0;
				end
			end else if (!is_digit) begin
				tok_ok_d = 1'b0;
			end else if (pos_q < POS_DOT1) begin
				acc_day_d = DAY_W'((acc_day_q << 3) + (acc_day_q << 1) + DAY_W'(digit));
			end else if (pos_q < POS_DOT2) begin
				acc_month_d = MON_W'((acc_month_q << 3) + (acc_month_q << 1)
					+ MON_W'(digit));
			end else begin
				acc_year_d = YEAR_W'((acc_year_q << 3) + (acc_year_q << 1)
					+ YEAR_W'(digit));
			end
			if (pos_q < POS_SAT) begin
				pos_d = pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			tok_ok_q     <= 1'b1;
			acc_day_q    <= '0;
			acc_month_q  <= '0;
			acc_year_q   <= '0;
			best_day_q   <= '0;
			best_month_q <= '0;
			best_year_q  <= '0;
			have_best_q  <= 1'b0;
		end else if (fire) begin
			pos_q        <= pos_d;
			tok_ok_q     <= tok_ok_d;
			acc_day_q    <= acc_day_d;
			acc_month_q  <= acc_month_d;
			acc_year_q   <= acc_year_d;
			best_day_q   <= best_day_d;
			best_month_q <= best_month_d;
			best_year_q  <= best_year_d;
			have_best_q  <= have_best_d;
		end
	end

endmodule

### hw/rtl/earliest_date_token_scanner_unit.sv
// Earliest date scanner: input register, scanner core and result register.
`timescale 1ns / 1ps

// Scans a byte stream for whitespace-separated tokens of the form DD.MM.YYYY
// and reports the earliest one (by year, then month, then day) when a
// transaction with end_of_text set arrives; ch is ignored on that transaction.
// Only the end-of-text transaction produces a result, and the block then
// starts a fresh stream. One byte is accepted per cycle: a byte lands in the
// input register, the scanner core updates its state from it, and an
// end-of-text transaction also writes the result register. Input is
// stalled only while an end-of-text transaction waits for the result
// register to be freed by out_ready.
module earliest_date_token_scanner_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [edts_pkg::CH_W-1:0]   ch,
	input  logic                        end_of_text,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [edts_pkg::DAY_W-1:0]  best_day_out,
	output logic [edts_pkg::MON_W-1:0]  best_month_out,
	output logic [edts_pkg::YEAR_W-1:0] best_year_out
);
	import edts_pkg::*;

	logic    in_valid_s1;
	step_t   in_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t core_res;
	logic    out_free;
	logic    advance;
	logic    fire;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = !in_valid_s1 || !in_s1.eot || out_free;
	assign fire     = in_valid_s1 && advance;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (advance) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && advance) begin
			in_s1.ch  <= ch;
			in_s1.eot <= end_of_text;
		end
	end

	edts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.step   (in_s1),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && in_s1.eot) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && in_s1.eot) begin
			out_q <= core_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = out_q.found;
	assign best_day_out   = out_q.day;
	assign best_month_out = out_q.month;
	assign best_year_out  = out_q.year;

endmodule

### bench/earliest_date_token_scanner_unit_tb.sv
// Self-checking testbench for the earliest date token scanner unit.
`timescale 1ns / 1ps

module earliest_date_token_scanner_unit_tb;
	import edts_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 1550;
	localparam int unsigned TAIL_CYCLES  = 8;

	typedef struct {
		logic [CH_W-1:0] ch;
		logic            eot;
		bit              hold_for_drain;
	} text_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CH_W-1:0]     ch = '0;
	logic                end_of_text = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                found;
	logic [DAY_W-1:0]    best_day_out;
	logic [MON_W-1:0]    best_month_out;
	logic [YEAR_W-1:0]   best_year_out;

	text_item_t          pending_text[$];
	result_t             expected_dates[$];
	logic [CH_W-1:0]     token_buf[$];
	bit                  drain_next;
	int unsigned         queued_count;

	// Mirror of the scanner: current token and earliest date kept so far.
	logic [POS_W-1:0]    tok_pos;
	bit                  tok_ok;
	logic [DAY_W-1:0]    tok_day;
	logic [MON_W-1:0]    tok_month;
	logic [YEAR_W-1:0]   tok_year;
	logic [DAY_W-1:0]    kept_day;
	logic [MON_W-1:0]    kept_month;
	logic [YEAR_W-1:0]   kept_year;
	bit                  kept_valid;

	int unsigned         items_accepted;
	int unsigned         streams_done;
	int unsigned         dates_reported;
	int unsigned         error_count;
	int unsigned         cycle_count;
	int unsigned         send_idle;
	int unsigned         send_burst;
	int unsigned         recv_stall;
	int unsigned         recv_burst;

	earliest_date_token_scanner_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ch             (ch),
		.end_of_text    (end_of_text),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.best_day_out   (best_day_out),
		.best_month_out (best_month_out),
		.best_year_out  (best_year_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit is_blank(logic [CH_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic clear_token_mirror();
		tok_pos   = '0;
		tok_ok    = 1'b1;
		tok_day   = '0;
		tok_month = '0;
		tok_year  = '0;
	endtask

	task automatic reset_scanner_mirror();
		clear_token_mirror();
		kept_day   = '0;
		kept_month = '0;
		kept_year  = '0;
		kept_valid = 1'b0;
	endtask

	task automatic close_token_mirror();
		bit earlier;
		if (tok_ok && tok_pos == DATE_LEN) begin
			if (!kept_valid)
				earlier = 1'b1;
			else if (tok_year != kept_year)
				earlier = tok_year < kept_year;
			else if (tok_month != kept_month)
				earlier = tok_month < kept_month;
			else
				earlier = tok_day < kept_day;
			if (earlier) begin
				kept_day   = tok_day;
				kept_month = tok_month;
				kept_year  = tok_year;
				kept_valid = 1'b1;
			end
		end
		clear_token_mirror();
	endtask

	task automatic take_token_byte(input logic [CH_W-1:0] c);
		bit       is_digit;
		logic [3:0] d;
		is_digit = c >= CH_ZERO && c <= CH_NINE;
		d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
		if (tok_pos >= DATE_LEN) begin
			tok_ok = 1'b0;
		end else if (tok_pos == POS_DOT1 || tok_pos == POS_DOT2) begin
			if (c != CH_DOT)
				tok_ok = 1'b0;
		end else if (!is_digit) begin
			tok_ok = 1'b0;
		end else if (tok_pos < POS_DOT1) begin
			tok_day = DAY_W'(tok_day * 10 + d);
		end else if (tok_pos < POS_DOT2) begin
			tok_month = MON_W'(tok_month * 10 + d);
		end else begin
			tok_year = YEAR_W'(tok_year * 10 + d);
		end
		if (tok_pos < POS_SAT)
			tok_pos = tok_pos + 1'b1;
	endtask

	// Advances the mirror by one accepted transaction and queues the result it causes.
	task automatic scan_text_item(input logic [CH_W-1:0] c, input logic eot);
		result_t r;
		if (!eot) begin
			if (is_blank(c))
				close_token_mirror();
			else
				take_token_byte(c);
		end else begin
			close_token_mirror();
			r.found = kept_valid;
			r.day   = kept_valid ? kept_day : '0;
			r.month = kept_valid ? kept_month : '0;
			r.year  = kept_valid ? kept_year : '0;
			expected_dates.push_back(r);
			reset_scanner_mirror();
		end
	endtask

	function automatic int unsigned pick_gap(inout int unsigned burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if (r < 3) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 58)
			return 0;
		if (r < 94)
			return $urandom_range(1, 4);
		return $urandom_range(12, 40);
	endfunction

	task automatic queue_item(input logic [CH_W-1:0] c, input logic eot);
		text_item_t item;
		item.ch = c;
		item.eot = eot;
		item.hold_for_drain = drain_next;
		drain_next = 1'b0;
		pending_text.push_back(item);
		queued_count++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_item(s[i], 1'b0);
	endtask

	function automatic logic [CH_W-1:0] random_blank();
		int unsigned idx;
		idx = $urandom_range(0, 5);
		return (idx == 5) ? CH_SPACE : CH_TAB + CH_W'(idx);
	endfunction

	function automatic logic [CH_W-1:0] random_solid_byte();
		logic [CH_W-1:0] c;
		do
			c = CH_W'($urandom_range(0, 255));
		while (is_blank(c));
		return c;
	endfunction

	task automatic push_decimal(input int unsigned value, input int unsigned digits);
		int unsigned div;
		div = 1;
		repeat (digits - 1)
			div *= 10;
		while (div > 0) begin
			token_buf.push_back(CH_ZERO + CH_W'((value / div) % 10));
			div /= 10;
		end
	endtask

	// Day and month come from narrow ranges half the time and year two times in
	// three, so that ties on year and month are common and the finer comparisons get exercised.
	task automatic build_date();
		int unsigned dd;
		int unsigned mm;
		int unsigned yy;
		dd = $urandom_range(0, 1) ? $urandom_range(0, 99) : $urandom_range(1, 3);
		mm = $urandom_range(0, 1) ? $urandom_range(0, 99) : $urandom_range(1, 3);
		yy = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9999) : $urandom_range(1998, 2001);
		push_decimal(dd, 2);
		token_buf.push_back(CH_DOT);
		push_decimal(mm, 2);
		token_buf.push_back(CH_DOT);
		push_decimal(yy, 4);
	endtask

	task automatic queue_blanks();
		repeat ($urandom_range(1, 3))
			queue_item(random_blank(), 1'b0);
	endtask

	task automatic queue_random_token();
		int unsigned kind;
		int unsigned n;
		kind = $urandom_range(0, 99);
		token_buf.delete();
		if (kind < 86)
			build_date();
		if (kind >= 60 && kind < 70) begin
			token_buf[$urandom_range(0, 9)] = random_solid_byte();
		end else if (kind >= 70 && kind < 78) begin
			repeat ($urandom_range(1, 6))
				token_buf.push_back($urandom_range(0, 1) ? CH_ZERO + CH_W'($urandom_range(0, 9))
					: random_solid_byte());
		end else if (kind >= 78 && kind < 86) begin
			n = $urandom_range(1, 9);
			while (token_buf.size() > n)
				void'(token_buf.pop_back());
		end else if (kind >= 86) begin
			repeat ($urandom_range(1, 14))
				token_buf.push_back(random_solid_byte());
		end
		foreach (token_buf[i])
			queue_item(token_buf[i], 1'b0);
	endtask

	task automatic queue_random_stream();
		int unsigned n_tok;
		n_tok = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			queue_blanks();
		for (int unsigned i = 0; i < n_tok; i++) begin
			queue_random_token();
			if (i + 1 < n_tok || $urandom_range(0, 1) == 1)
				queue_blanks();
		end
		queue_item(CH_W'($urandom_range(0, 255)), 1'b1);
	endtask

	// Sender: presents one pending transaction at a time with random gaps.
	always @(posedge clk or negedge arst_n) begin
		text_item_t item;
		logic drive_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= '0;
			end_of_text <= 1'b0;
			send_idle = 0;
			send_burst = 0;
		end else begin
			drive_valid = in_valid;
			if (in_valid && in_ready) begin
				scan_text_item(ch, end_of_text);
				items_accepted++;
				drive_valid = 1'b0;
				send_idle = pick_gap(send_burst);
			end
			if (!drive_valid) begin
				if (send_idle > 0) begin
					send_idle--;
				end else if (pending_text.size() != 0 &&
						!(pending_text[0].hold_for_drain && expected_dates.size() != 0)) begin
					item = pending_text.pop_front();
					ch <= item.ch;
					end_of_text <= item.eot;
					drive_valid = 1'b1;
				end
			end
			in_valid <= drive_valid;
		end
	end

	// Receiver: stalls at random and checks every result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
			recv_burst = 0;
		end else begin
			if (out_valid && out_ready) begin
				streams_done++;
				if (found)
					dates_reported++;
				if (expected_dates.size() == 0) begin
					$error("result with no transaction pending: found %0d date %0d.%0d.%0d",
						found, best_day_out, best_month_out, best_year_out);
					error_count++;
				end else begin
					want = expected_dates.pop_front();
					if (found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, found);
						error_count++;
					end
					if (best_day_out !== want.day) begin
						$error("best_day_out: expected %0d, actual %0d", want.day, best_day_out);
						error_count++;
					end
					if (best_month_out !== want.month) begin
						$error("best_month_out: expected %0d, actual %0d", want.month,
							best_month_out);
						error_count++;
					end
					if (best_year_out !== want.year) begin
						$error("best_year_out: expected %0d, actual %0d", want.year,
							best_year_out);
						error_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				recv_stall = pick_gap(recv_burst);
				if (recv_stall > 0) begin
					recv_stall--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("earliest_date_token_scanner_unit test failed");
			$finish;
		end
	end

	initial begin
		bit mid_drain_done;
		int unsigned directed_count;
		mid_drain_done = 1'b0;
		reset_scanner_mirror();

		// An empty stream, a date closed by end of text alone, and the
		// all-zero date between unusual separators.
		queue_item(8'hFF, 1'b1);
		queue_text("31.12.9999");
		queue_item(CH_ZERO + 8'd5, 1'b1);
		queue_item(8'h0B, 1'b0);
		queue_text("00.00.0000");
		queue_item(8'h0C, 1'b0);
		queue_item(CH_CR, 1'b0);
		queue_item(8'h00, 1'b1);
		directed_count = queued_count;

		// The first random stream waits until the directed results are all in.
		drain_next = 1'b1;
		while (queued_count < directed_count + RANDOM_ITEMS) begin
			if (!mid_drain_done && queued_count >= directed_count + RANDOM_ITEMS / 2) begin
				drain_next = 1'b1;
				mid_drain_done = 1'b1;
			end
			queue_random_stream();
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_text.size() != 0 || in_valid || expected_dates.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Scanned %0d transactions in %0d streams; %0d streams reported a date.",
			items_accepted, streams_done, dates_reported);
		$display("Streams mixed dates with corrupted, long, short and noise tokens.");
		if (error_count == 0 && expected_dates.size() == 0)
			$display("earliest_date_token_scanner_unit test passed");
		else
			$display("earliest_date_token_scanner_unit test failed");
		$finish;
	end

endmodule
